FILE: design/ppi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppi_pkg
// Shared constants, register codes and the vertex path of the polyline
// phase interpolator.
// ----------------------------------------------------------------------------
package ppi_pkg;

    localparam int PHASE_FRAC_BITS_DEF  = 16;
    localparam int SAMPLE_FRAC_BITS_DEF = 12;

    localparam int NUM_VERTS  = 12;
    localparam int VIDX_W     = 4;
    localparam int NUM_AXES   = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int PIPE_DEPTH = 5;

    localparam logic [VIDX_W-1:0] LAST_VERT = VIDX_W'(NUM_VERTS - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OFFSET_X = 3'd0,
        REG_OFFSET_Y = 3'd1,
        REG_OFFSET_Z = 3'd2,
        REG_GAIN_X   = 3'd3,
        REG_GAIN_Y   = 3'd4,
        REG_GAIN_Z   = 3'd5
    } t_cfg_reg;

    // Vertex coordinate in half units (-1, 0, +1) for one axis (0 = x).
    function automatic logic signed [1:0] vert_half(input logic [VIDX_W-1:0] idx,
                                                    input logic [1:0] axis);
        logic [5:0] xyz;
        begin
            case (idx)
                4'd0:    xyz = 6'b11_11_00;
                4'd1:    xyz = 6'b11_01_00;
                4'd2:    xyz = 6'b00_00_11;
                4'd3:    xyz = 6'b11_11_00;
                4'd4:    xyz = 6'b01_11_00;
                4'd5:    xyz = 6'b00_00_11;
                4'd6:    xyz = 6'b01_01_00;
                4'd7:    xyz = 6'b01_11_00;
                4'd8:    xyz = 6'b00_00_01;
                4'd9:    xyz = 6'b01_01_00;
                4'd10:   xyz = 6'b11_01_00;
                4'd11:   xyz = 6'b00_00_01;
                default: xyz = 6'b00_00_00;
            endcase
            case (axis)
                2'd0:    vert_half = xyz[5:4];
                2'd1:    vert_half = xyz[3:2];
                default: vert_half = xyz[1:0];
            endcase
        end
    endfunction

endpackage

FILE: design/ppi_phase.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppi_phase
// Two stages: scale the phase fraction by 12, then multiply by the amount
// and pick the vertex index and the interpolation fraction.
// ----------------------------------------------------------------------------
module ppi_phase
    import ppi_pkg::*;
#(
    parameter int PHASE_FRAC_BITS  = PHASE_FRAC_BITS_DEF,
    parameter int SAMPLE_FRAC_BITS = SAMPLE_FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic signed [23:0]          i_drive_phase,
    input  logic signed [15:0]          i_interp_amount,
    output logic [VIDX_W-1:0]           o_idx,
    output logic [SAMPLE_FRAC_BITS-1:0] o_frac
);

    localparam int PF = PHASE_FRAC_BITS;
    localparam int SF = SAMPLE_FRAC_BITS;
    localparam int TW = PF + 4;

    logic [PF-1:0]         w_t;
    logic [TW-1:0]         w_t2;
    logic [TW-1:0]         r_t2;
    logic signed [15:0]    r_amt;
    logic signed [TW+16:0] w_prod;
    logic [VIDX_W-1:0]     w_idx;
    logic [VIDX_W-1:0]     r_idx;
    logic [SF-1:0]         r_frac;

    // 12*t as 8*t + 4*t
    assign w_t  = i_drive_phase[PF-1:0];
    assign w_t2 = {1'b0, w_t, 3'b000} + {2'b00, w_t, 2'b00};

    always_ff @(posedge i_clk) begin
        r_t2  <= w_t2;
        r_amt <= i_interp_amount;
    end

    // only the low bits of the product matter: floor modulo of two's complement
    assign w_prod = $signed({1'b0, r_t2}) * r_amt;
    assign w_idx  = (r_t2[TW-1:PF] > LAST_VERT) ? LAST_VERT : r_t2[TW-1:PF];

    always_ff @(posedge i_clk) begin
        r_idx  <= w_idx;
        r_frac <= w_prod[PF+SF-1:PF];
    end

    assign o_idx  = r_idx;
    assign o_frac = r_frac;

endmodule

FILE: design/ppi_lerp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppi_lerp
// Looks up the current and next vertex and interpolates all three axes.
// ----------------------------------------------------------------------------
module ppi_lerp
    import ppi_pkg::*;
#(
    parameter int SAMPLE_FRAC_BITS = SAMPLE_FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic [VIDX_W-1:0]             i_idx,
    input  logic [SAMPLE_FRAC_BITS-1:0]   i_frac,
    output logic signed [SAMPLE_FRAC_BITS+1:0] o_lerp [NUM_AXES]
);

    localparam int SF = SAMPLE_FRAC_BITS;
    localparam int LW = SF + 2;

    logic [VIDX_W-1:0]     w_nxt;
    logic signed [LW:0]    w_sum  [NUM_AXES];
    logic signed [LW-1:0]  r_lerp [NUM_AXES];

    // wrap from the last vertex back to the first
    assign w_nxt = (i_idx == LAST_VERT) ? '0 : i_idx + VIDX_W'(1);

    always_comb begin
        logic signed [2:0]  a;
        logic signed [2:0]  b;
        logic signed [2:0]  d;
        logic signed [LW:0] fe;
        logic signed [LW:0] base;
        for (int ax = 0; ax < NUM_AXES; ax++) begin
            a    = 3'(vert_half(i_idx, 2'(ax)));
            b    = 3'(vert_half(w_nxt, 2'(ax)));
            d    = b - a;
            fe   = $signed({3'b000, i_frac});
            base = $signed({a, {SF{1'b0}}});
            w_sum[ax] = base + fe * d;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int ax = 0; ax < NUM_AXES; ax++) begin
            r_lerp[ax] <= w_sum[ax][LW-1:0];
        end
    end

    assign o_lerp = r_lerp;

endmodule

FILE: design/ppi_axis.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppi_axis
// One axis: multiply by gain with rounding, then add offset and saturate.
// ----------------------------------------------------------------------------
module ppi_axis
    import ppi_pkg::*;
#(
    parameter int SAMPLE_FRAC_BITS = SAMPLE_FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic signed [SAMPLE_FRAC_BITS+1:0] i_lerp,
    input  logic signed [15:0]                 i_gain,
    input  logic signed [15:0]                 i_offset,
    output logic signed [15:0]                 o_coord
);

    localparam int SF = SAMPLE_FRAC_BITS;
    localparam int LW = SF + 2;
    localparam int PW = LW + 16;
    localparam int QW = PW - (SF + 1);

    localparam logic signed [PW-1:0] RND    = {{(PW-SF-1){1'b0}}, 1'b1, {SF{1'b0}}};
    localparam logic signed [QW:0]   SAT_HI = (QW+1)'(32767);
    localparam logic signed [QW:0]   SAT_LO = -(QW+1)'(32768);

    logic signed [PW-1:0] w_prod;
    logic signed [PW-1:0] r_prod;
    logic signed [QW-1:0] w_q;
    logic signed [QW:0]   w_sum;
    logic signed [15:0]   w_sat;
    logic signed [15:0]   r_coord;

    assign w_prod = i_lerp * i_gain;

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod + RND;
    end

    // drop the extra lerp bit and the fraction bits (floor)
    assign w_q   = r_prod[PW-1:SF+1];
    assign w_sum = {w_q[QW-1], w_q} + {{(QW+1-16){i_offset[15]}}, i_offset};

    always_comb begin
        if (w_sum > SAT_HI) begin
            w_sat = 16'sh7FFF;
        end else if (w_sum < SAT_LO) begin
            w_sat = 16'sh8000;
        end else begin
            w_sat = w_sum[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_coord <= w_sat;
    end

    assign o_coord = r_coord;

endmodule

FILE: design/polyline_3d_phase_interpolator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyline_3d_phase_interpolator
// Maps a phase sample onto a 12-vertex 3-D path and returns a scaled,
// offset and saturated (x, y, z) point.
// ----------------------------------------------------------------------------
// The block accepts one item in every clock cycle (busy stays low) and
// returns its point with o_valid high for one cycle; the five register
// stages are phase scaling, the amount multiply, vertex lookup and
// interpolation, the gain multiply, and the offset add with saturation.
// The receiver cannot stall it, so a result must be taken in the cycle it
// is shown. Write gain and offset registers only while no item is in
// flight.
module polyline_3d_phase_interpolator
    import ppi_pkg::*;
#(
    parameter int PHASE_FRAC_BITS  = PHASE_FRAC_BITS_DEF,
    parameter int SAMPLE_FRAC_BITS = SAMPLE_FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic signed [23:0]    i_drive_phase,
    input  logic signed [15:0]    i_interp_amount,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_valid,
    output logic signed [15:0]    o_out_x,
    output logic signed [15:0]    o_out_y,
    output logic signed [15:0]    o_out_z
);

    localparam int SF = SAMPLE_FRAC_BITS;

    logic signed [15:0]    r_offset [NUM_AXES];
    logic signed [15:0]    r_gain   [NUM_AXES];
    logic [PIPE_DEPTH-1:0] r_vld;
    logic [VIDX_W-1:0]     w_idx;
    logic [SF-1:0]         w_frac;
    logic signed [SF+1:0]  w_lerp   [NUM_AXES];
    logic signed [15:0]    w_coord  [NUM_AXES];

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset[0] <= '0;
            r_offset[1] <= '0;
            r_offset[2] <= '0;
            r_gain[0]   <= 16'sd4096;
            r_gain[1]   <= 16'sd4096;
            r_gain[2]   <= 16'sd4096;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_OFFSET_X: r_offset[0] <= i_cfg_data;
                REG_OFFSET_Y: r_offset[1] <= i_cfg_data;
                REG_OFFSET_Z: r_offset[2] <= i_cfg_data;
                REG_GAIN_X:   r_gain[0]   <= i_cfg_data;
                REG_GAIN_Y:   r_gain[1]   <= i_cfg_data;
                REG_GAIN_Z:   r_gain[2]   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // valid bits travel alongside the data stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], start & ~busy};
        end
    end

    ppi_phase #(
        .PHASE_FRAC_BITS  (PHASE_FRAC_BITS),
        .SAMPLE_FRAC_BITS (SAMPLE_FRAC_BITS)
    ) u_phase (
        .i_clk           (i_clk),
        .i_drive_phase   (i_drive_phase),
        .i_interp_amount (i_interp_amount),
        .o_idx           (w_idx),
        .o_frac          (w_frac)
    );

    ppi_lerp #(
        .SAMPLE_FRAC_BITS (SAMPLE_FRAC_BITS)
    ) u_lerp (
        .i_clk  (i_clk),
        .i_idx  (w_idx),
        .i_frac (w_frac),
        .o_lerp (w_lerp)
    );

    for (genvar ax = 0; ax < NUM_AXES; ax++) begin : g_axis
        ppi_axis #(
            .SAMPLE_FRAC_BITS (SAMPLE_FRAC_BITS)
        ) u_axis (
            .i_clk    (i_clk),
            .i_lerp   (w_lerp[ax]),
            .i_gain   (r_gain[ax]),
            .i_offset (r_offset[ax]),
            .o_coord  (w_coord[ax])
        );
    end

    assign o_valid = r_vld[PIPE_DEPTH-1];
    assign o_out_x = w_coord[0];
    assign o_out_y = w_coord[1];
    assign o_out_z = w_coord[2];

endmodule

FILE: design/ppi_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppi_checker
// Port-level checks of the polyline phase interpolator, bound to the top.
// ----------------------------------------------------------------------------
module ppi_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_valid
);

    // the pipeline takes an item in every cycle
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised");

    // every accepted item yields a result on o_valid
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##5 o_valid)
        else $error("accepted item produced no result");

    // no result without an earlier accepted item
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(start, 5) && !$past(busy, 5)))
        else $error("result without an accepted item");

endmodule

bind polyline_3d_phase_interpolator ppi_checker u_ppi_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_valid (o_valid)
);

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the polyline phase interpolator. A directed table
// covers every vertex, the field extremes, negative phase, zero amount,
// saturation and writes to unused register slots. Random phases and ramps
// follow under several gain/offset settings. Every point is compared per
// axis against an in-bench model of the fixed-point interpolation.
// ----------------------------------------------------------------------------
module tb;
    import ppi_pkg::*;

    localparam int PB          = PHASE_FRAC_BITS_DEF;
    localparam int FB          = SAMPLE_FRAC_BITS_DEF;
    localparam int PER_PHASE   = 225;
    localparam int QUIET_LIMIT = 2000;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam logic [15:0] GAIN_UNITY = 16'h1000;
    localparam logic [15:0] S16_MAX    = 16'h7FFF;
    localparam logic [15:0] S16_MIN    = 16'h8000;

    typedef logic [0:2][15:0] t_point;

    typedef enum logic { ROW_ITEM, ROW_CFG } t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        logic [23:0] arg_a;   // phase, or register index
        logic [15:0] arg_b;   // amount, or register data
        logic        typed;   // expected point given in the row
        t_point      pt;
    } t_stim_row;

    typedef enum int {
        SET_DEFAULT, SET_RANDOM, SET_TOP, SET_BOTTOM, SET_OPPOSED, SET_MODEST
    } t_setting;

    logic               i_clk           = 1'b0;
    logic               i_rst_n         = 1'b0;
    logic               start           = 1'b0;
    logic               busy;
    logic [23:0]        i_drive_phase   = '0;
    logic [15:0]        i_interp_amount = '0;
    logic               i_cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data   = '0;
    logic               o_valid;
    logic signed [15:0] o_out_x;
    logic signed [15:0] o_out_y;
    logic signed [15:0] o_out_z;

    // model copy of the gain and offset registers, index 0 = x
    logic signed [15:0] gain_m [0:2];
    logic signed [15:0] offs_m [0:2];

    t_point    pending_points [$];
    t_stim_row dir_rows [$];

    bit cfg_open     = 1'b0;
    int err_cnt      = 0;
    int items_sent   = 0;
    int results_seen = 0;
    int cfg_writes   = 0;
    int settings_run = 0;
    int quiet_cycles = 0;

    always #4 i_clk = ~i_clk;

    polyline_3d_phase_interpolator DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_drive_phase   (i_drive_phase),
        .i_interp_amount (i_interp_amount),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .o_valid         (o_valid),
        .o_out_x         (o_out_x),
        .o_out_y         (o_out_y),
        .o_out_z         (o_out_z)
    );

    // Path vertex coordinate in half units (-1, 0, +1); axis 0 = x.
    function automatic int vertex_half(input int v, input int ax);
        int vx, vy, vz;
        case (v)
            0:       begin vx = -1; vy = -1; vz =  0; end
            1:       begin vx = -1; vy =  1; vz =  0; end
            2:       begin vx =  0; vy =  0; vz = -1; end
            3:       begin vx = -1; vy = -1; vz =  0; end
            4:       begin vx =  1; vy = -1; vz =  0; end
            5:       begin vx =  0; vy =  0; vz = -1; end
            6:       begin vx =  1; vy =  1; vz =  0; end
            7:       begin vx =  1; vy = -1; vz =  0; end
            8:       begin vx =  0; vy =  0; vz =  1; end
            9:       begin vx =  1; vy =  1; vz =  0; end
            10:      begin vx = -1; vy =  1; vz =  0; end
            default: begin vx =  0; vy =  0; vz =  1; end
        endcase
        if (ax == 0) return vx;
        if (ax == 1) return vy;
        return vz;
    endfunction

    function automatic t_point predict_point(input logic [23:0] phase,
                                             input logic [15:0] amount);
        longint ramp, prod, frac, lerp, scaled, sum;
        int seg, nxt, ax, va, vb;
        t_point pt;
        ramp = longint'(phase[PB-1:0]) * NUM_VERTS;
        seg  = int'(ramp >>> PB);
        if (seg > NUM_VERTS - 1) seg = NUM_VERTS - 1;
        nxt  = (seg == NUM_VERTS - 1) ? 0 : seg + 1;
        prod = ramp * longint'($signed(amount));
        // floor-modulo fraction, cut to the sample precision
        frac = longint'(prod[PB+FB-1:PB]);
        for (ax = 0; ax < NUM_AXES; ax++) begin
            va     = vertex_half(seg, ax);
            vb     = vertex_half(nxt, ax);
            lerp   = longint'(va) * (longint'(1) << FB) + frac * longint'(vb - va);
            scaled = lerp * longint'(gain_m[ax]) + (longint'(1) << FB);
            sum    = (scaled >>> (FB + 1)) + longint'(offs_m[ax]);
            if (sum > 32767) sum = 32767;
            else if (sum < -32768) sum = -32768;
            pt[ax] = sum[15:0];
        end
        return pt;
    endfunction

    function automatic t_stim_row mk_row(input t_row_kind kind, input logic [23:0] a,
                                         input logic [15:0] b, input logic typed,
                                         input t_point pt);
        t_stim_row r;
        r.kind  = kind;
        r.arg_a = a;
        r.arg_b = b;
        r.typed = typed;
        r.pt    = pt;
        return r;
    endfunction

    function automatic logic [23:0] pick_phase();
        int v;
        logic [15:0] lo;
        logic [23:0] ph;
        case ($urandom_range(0, 5))
            0: begin
                // land on or next to a vertex boundary
                v  = $urandom_range(0, NUM_VERTS - 1);
                lo = 16'((v * 65536 + 11) / 12 + $urandom_range(0, 4) - 2);
                ph = {8'($urandom), lo};
            end
            1: ph = {8'($urandom), ($urandom_range(0, 1) ? 16'hFFFF : 16'h0000)};
            default: ph = 24'($urandom);
        endcase
        return ph;
    endfunction

    function automatic logic [15:0] pick_amount();
        logic [15:0] am;
        case ($urandom_range(0, 7))
            0:       am = 16'h0000;
            1:       am = GAIN_UNITY;
            2:       am = S16_MAX;
            3:       am = S16_MIN;
            4:       am = 16'($urandom_range(0, 1024)) - 16'd512;
            default: am = 16'($urandom);
        endcase
        return am;
    endfunction

    // Hold start low until every pending point has come back.
    task automatic drain_pipe();
        start <= 1'b0;
        if (cfg_open) begin
            i_cfg_we <= 1'b0;
            cfg_open = 1'b0;
        end
        while (pending_points.size() != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        if (!cfg_open) drain_pipe();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        cfg_open = 1'b1;
        cfg_writes++;
        case (idx)
            REG_OFFSET_X: offs_m[0] = data;
            REG_OFFSET_Y: offs_m[1] = data;
            REG_OFFSET_Z: offs_m[2] = data;
            REG_GAIN_X:   gain_m[0] = data;
            REG_GAIN_Y:   gain_m[1] = data;
            REG_GAIN_Z:   gain_m[2] = data;
            default: ;
        endcase
    endtask

    task automatic send_item(input logic [23:0] ph, input logic [15:0] am,
                             input t_point want);
        start           <= 1'b1;
        i_drive_phase   <= ph;
        i_interp_amount <= am;
        if (cfg_open) begin
            i_cfg_we <= 1'b0;
            cfg_open = 1'b0;
        end
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_points.push_back(want);
        items_sent++;
    endtask

    task automatic maybe_idle(input bit allow);
        int n;
        if (allow && $urandom_range(0, 11) == 0) begin
            n = $urandom_range(1, 19);
            start <= 1'b0;
            if (cfg_open) begin
                i_cfg_we <= 1'b0;
                cfg_open = 1'b0;
            end
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic program_settings(input t_setting mode);
        int ax;
        logic [15:0] g, o;
        for (ax = 0; ax < NUM_AXES; ax++) begin
            case (mode)
                SET_DEFAULT: begin g = GAIN_UNITY; o = 16'h0000; end
                SET_TOP:     begin g = S16_MAX; o = S16_MAX; end
                SET_BOTTOM:  begin g = S16_MIN; o = S16_MIN; end
                SET_OPPOSED: begin
                    g = $urandom_range(0, 1) ? S16_MAX : S16_MIN;
                    o = (g == S16_MAX) ? S16_MIN : S16_MAX;
                end
                SET_MODEST: begin
                    g = 16'($urandom_range(0, 16384)) - 16'd8192;
                    o = 16'($urandom_range(0, 8192)) - 16'd4096;
                end
                default: begin g = 16'($urandom); o = 16'($urandom); end
            endcase
            cfg_write(CFG_IDX_W'(REG_OFFSET_X + ax), o);
            cfg_write(CFG_IDX_W'(REG_GAIN_X + ax), g);
        end
        // unused slots must leave the point untouched
        if ($urandom_range(0, 2) == 0)
            cfg_write($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, 16'($urandom));
        settings_run++;
    endtask

    task automatic run_phase(input t_setting mode, input int count, input bit allow_idle);
        int n, len, k;
        logic [23:0] ph, ph_step;
        logic [15:0] am;
        program_settings(mode);
        n = 0;
        while (n < count) begin
            if ($urandom_range(0, 1)) begin
                // oscillator-like sweep: steady phase increment, fixed amount
                len     = $urandom_range(8, 40);
                ph      = 24'($urandom);
                ph_step = 24'($urandom_range(1, 4000));
                if ($urandom_range(0, 1)) ph_step = -ph_step;
                am      = pick_amount();
                for (k = 0; k < len && n < count; k++) begin
                    send_item(ph, am, predict_point(ph, am));
                    maybe_idle(allow_idle);
                    ph = ph + ph_step;
                    n++;
                end
            end else begin
                ph = pick_phase();
                am = pick_amount();
                send_item(ph, am, predict_point(ph, am));
                maybe_idle(allow_idle);
                n++;
            end
        end
    endtask

    // Compare each returned point with the oldest pending one.
    always @(posedge i_clk) begin
        t_point want, got;
        int ax;
        string nm;
        if (i_rst_n && o_valid) begin
            got = {o_out_x, o_out_y, o_out_z};
            if (pending_points.size() == 0) begin
                $error("result with no item pending: x=%0d y=%0d z=%0d",
                       o_out_x, o_out_y, o_out_z);
                err_cnt++;
            end else begin
                want = pending_points.pop_front();
                results_seen++;
                for (ax = 0; ax < NUM_AXES; ax++) begin
                    if (want[ax] !== got[ax]) begin
                        case (ax)
                            0:       nm = "out_x";
                            1:       nm = "out_y";
                            default: nm = "out_z";
                        endcase
                        $error("%s mismatch: expected %0d, got %0d",
                               nm, $signed(want[ax]), $signed(got[ax]));
                        err_cnt++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid || i_cfg_we) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no activity for %0d cycles, %0d points pending",
                     quiet_cycles, pending_points.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        t_stim_row r;
        int i;
        for (i = 0; i < NUM_AXES; i++) begin
            gain_m[i] = GAIN_UNITY;
            offs_m[i] = '0;
        end

        // zero amount returns the vertex itself: +-0.5 is +-2048
        dir_rows.push_back(mk_row(ROW_ITEM, 24'h000000, 16'h0000, 1'b1,
                                  {16'hF800, 16'hF800, 16'h0000}));
        dir_rows.push_back(mk_row(ROW_ITEM, 24'h7F1556, 16'h0000, 1'b1,
                                  {16'hF800, 16'h0800, 16'h0000}));
        dir_rows.push_back(mk_row(ROW_ITEM, 24'h802AAB, 16'h0000, 1'b1,
                                  {16'h0000, 16'h0000, 16'hF800}));
        dir_rows.push_back(mk_row(ROW_ITEM, 24'hFF4000, 16'h0000, 1'b1,
                                  {16'hF800, 16'hF800, 16'h0000}));
        dir_rows.push_back(mk_row(ROW_ITEM, 24'h015556, 16'h0000, 1'b1,
                                  {16'h0800, 16'hF800, 16'h0000}));
        dir_rows.push_back(mk_row(ROW_ITEM, 24'hC36AAB, 16'h0000, 1'b1,
                                  {16'h0000, 16'h0000, 16'hF800}));
        dir_rows.push_back(mk_row(ROW_ITEM, 24'h558000, 16'h0000, 1'b1,
                                  {16'h0800, 16'h0800, 16'h0000}));
        dir_rows.push_back(mk_row(ROW_ITEM, 24'hAA9556, 16'h0000, 1'b1,
                                  {16'h0800, 16'hF800, 16'h0000}));
        dir_rows.push_back(mk_row(ROW_ITEM, 24'h00AAAB, 16'h0000, 1'b1,
                                  {16'h0000, 16'h0000, 16'h0800}));
        dir_rows.push_back(mk_row(ROW_ITEM, 24'h3CC000, 16'h0000, 1'b1,
                                  {16'h0800, 16'h0800, 16'h0000}));
        dir_rows.push_back(mk_row(ROW_ITEM, 24'hE1D556, 16'h0000, 1'b1,
                                  {16'hF800, 16'h0800, 16'h0000}));
        dir_rows.push_back(mk_row(ROW_ITEM, 24'h7FEAAB, 16'h0000, 1'b1,
                                  {16'h0000, 16'h0000, 16'h0800}));
        // negative phase wraps to its fraction: -1 lsb sits on the last vertex
        dir_rows.push_back(mk_row(ROW_ITEM, 24'hFFFFFF, 16'h0000, 1'b1,
                                  {16'h0000, 16'h0000, 16'h0800}));
        // zero fraction gives f = 0 whatever the amount
        dir_rows.push_back(mk_row(ROW_ITEM, 24'h800000, S16_MAX, 1'b1,
                                  {16'hF800, 16'hF800, 16'h0000}));
        dir_rows.push_back(mk_row(ROW_ITEM, 24'h7FFFFF, S16_MAX, 1'b0, '0));
        dir_rows.push_back(mk_row(ROW_ITEM, 24'h7FFFFF, S16_MIN, 1'b0, '0));
        dir_rows.push_back(mk_row(ROW_ITEM, 24'h123456, GAIN_UNITY, 1'b0, '0));
        dir_rows.push_back(mk_row(ROW_ITEM, 24'h00ABCD, 16'hF000, 1'b0, '0));
        dir_rows.push_back(mk_row(ROW_ITEM, 24'h005555, GAIN_UNITY, 1'b0, '0));
        dir_rows.push_back(mk_row(ROW_ITEM, 24'h9A6F31, 16'h0001, 1'b0, '0));
        dir_rows.push_back(mk_row(ROW_ITEM, 24'h4E2D19, 16'hFFFF, 1'b0, '0));
        // drive x and y into opposite saturation
        dir_rows.push_back(mk_row(ROW_CFG, 24'(REG_GAIN_X), S16_MIN, 1'b0, '0));
        dir_rows.push_back(mk_row(ROW_CFG, 24'(REG_OFFSET_X), S16_MAX, 1'b0, '0));
        dir_rows.push_back(mk_row(ROW_CFG, 24'(REG_GAIN_Y), S16_MAX, 1'b0, '0));
        dir_rows.push_back(mk_row(ROW_CFG, 24'(REG_OFFSET_Y), S16_MIN, 1'b0, '0));
        dir_rows.push_back(mk_row(ROW_ITEM, 24'h000000, 16'h0000, 1'b1,
                                  {16'h7FFF, 16'h8000, 16'h0000}));
        dir_rows.push_back(mk_row(ROW_ITEM, 24'h003000, 16'h2345, 1'b0, '0));
        // restore defaults, then poke the unused slots
        dir_rows.push_back(mk_row(ROW_CFG, 24'(REG_GAIN_X), GAIN_UNITY, 1'b0, '0));
        dir_rows.push_back(mk_row(ROW_CFG, 24'(REG_OFFSET_X), 16'h0000, 1'b0, '0));
        dir_rows.push_back(mk_row(ROW_CFG, 24'(REG_GAIN_Y), GAIN_UNITY, 1'b0, '0));
        dir_rows.push_back(mk_row(ROW_CFG, 24'(REG_OFFSET_Y), 16'h0000, 1'b0, '0));
        dir_rows.push_back(mk_row(ROW_CFG, 24'(REG_SPARE_LO), 16'hFFFF, 1'b0, '0));
        dir_rows.push_back(mk_row(ROW_CFG, 24'(REG_SPARE_HI), 16'h5A5A, 1'b0, '0));
        dir_rows.push_back(mk_row(ROW_ITEM, 24'h001556, 16'h0000, 1'b1,
                                  {16'hF800, 16'h0800, 16'h0000}));

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            r = dir_rows[i];
            if (r.kind == ROW_CFG) begin
                cfg_write(r.arg_a[CFG_IDX_W-1:0], r.arg_b);
            end else begin
                send_item(r.arg_a, r.arg_b,
                          r.typed ? r.pt : predict_point(r.arg_a, r.arg_b));
                maybe_idle(1'b1);
            end
        end

        run_phase(SET_DEFAULT, PER_PHASE, 1'b1);
        run_phase(SET_RANDOM,  PER_PHASE, 1'b1);
        run_phase(SET_TOP,     PER_PHASE, 1'b1);
        run_phase(SET_MODEST,  PER_PHASE, 1'b1);
        run_phase(SET_BOTTOM,  PER_PHASE, 1'b1);
        run_phase(SET_RANDOM,  PER_PHASE, 1'b1);
        run_phase(SET_OPPOSED, PER_PHASE, 1'b1);
        // last stretch runs back to back
        run_phase(SET_RANDOM,  PER_PHASE, 1'b0);

        drain_pipe();
        repeat (PIPE_DEPTH + 4) @(posedge i_clk);

        $display("Sent %0d items (%0d directed rows), checked %0d points", items_sent,
                 dir_rows.size(), results_seen);
        $display("Ran %0d gain/offset settings with %0d register writes, %0d errors",
                 settings_run, cfg_writes, err_cnt);
        if (err_cnt == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end

endmodule
